// File: rtl/core/fvos_pkg.sv
// Shared types, constants and the neighbor hop table of the FCC voxel occupancy store.
// Has no dependencies; the top level and the testbench take names from here.
package fvos_pkg;

    localparam int GRID_SIZE_DEF = 32;
    localparam int DIR_COUNT     = 12;
    localparam int COORD_W       = 7;
    localparam int PROBE_W       = 8;
    localparam int CNT_W         = 4;
    localparam int DIR_W         = 4;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_HOP   = 2'd2,
        OP_COUNT = 2'd3
    } t_opcode;

    typedef struct packed {
        logic signed [1:0] dx;
        logic signed [1:0] dy;
        logic signed [1:0] dz;
    } t_hop;

    // The twelve <1,1,0> neighbor offsets; codes past the table give no offset.
    function automatic t_hop hop_of(input logic [DIR_W-1:0] dir);
        t_hop h;
        h = '0;
        case (dir)
            4'd0: h = '{dx:  2'sd1, dy:  2'sd1, dz:  2'sd0};
            4'd1: h = '{dx:  2'sd1, dy: -2'sd1, dz:  2'sd0};
            4'd2: h = '{dx: -2'sd1, dy:  2'sd1, dz:  2'sd0};
            4'd3: h = '{dx: -2'sd1, dy: -2'sd1, dz:  2'sd0};
            4'd4: h = '{dx:  2'sd1, dy:  2'sd0, dz:  2'sd1};
            4'd5: h = '{dx:  2'sd1, dy:  2'sd0, dz: -2'sd1};
            4'd6: h = '{dx: -2'sd1, dy:  2'sd0, dz:  2'sd1};
            4'd7: h = '{dx: -2'sd1, dy:  2'sd0, dz: -2'sd1};
            4'd8: h = '{dx:  2'sd0, dy:  2'sd1, dz:  2'sd1};
            4'd9: h = '{dx:  2'sd0, dy:  2'sd1, dz: -2'sd1};
            4'd10: h = '{dx:  2'sd0, dy: -2'sd1, dz:  2'sd1};
            4'd11: h = '{dx:  2'sd0, dy: -2'sd1, dz: -2'sd1};
            default: h = '0;
        endcase
        return h;
    endfunction

endpackage

// File: rtl/core/fvos_row_mem.sv
// Single-port synchronous memory holding one row of occupancy bits per entry.
// Read data is registered. No package dependencies.
module fvos_row_mem #(
    parameter int AW = 10,
    parameter int DW = 32
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_addr,
    input  logic [DW-1:0] i_wdata,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/fcc_voxel_occupancy_store_top.sv
// Sequence: a write, read or neighbor read reads its row in the run state, and its result
// shows after the finishing state; a neighbor count reads one row per neighbor in turn.
// Beats: the next beat is taken in the cycle the result shows; no new beat is taken
// while busy is high, since every beat goes through the single row memory port.
// Reset: a clearing pass zeroes 2**(2*clog2(GRID_SIZE)) rows, one per cycle (1024 at the
// default size), with busy high. Results cannot be stalled. Uses fvos_pkg, fvos_row_mem.
module fcc_voxel_occupancy_store_top #(
    parameter int GRID_SIZE = fvos_pkg::GRID_SIZE_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         i_opcode,
    input  logic signed [fvos_pkg::COORD_W-1:0] i_coord_x,
    input  logic signed [fvos_pkg::COORD_W-1:0] i_coord_y,
    input  logic signed [fvos_pkg::COORD_W-1:0] i_coord_z,
    input  logic                               i_write_value,
    input  logic [fvos_pkg::DIR_W-1:0]         i_direction,
    output logic                               o_done,
    output logic                               o_write_accepted,
    output logic                               o_solid,
    output logic [fvos_pkg::CNT_W-1:0]         o_neighbor_count
);

    localparam int CW = $clog2(GRID_SIZE);
    localparam int AW = 2 * CW;
    localparam int RW = 1 << CW;
    localparam int PW = fvos_pkg::PROBE_W;
    localparam logic [PW-1:0] GRID_LIM = PW'(GRID_SIZE);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

    t_state                              r_state;
    logic [AW-1:0]                       r_clr;
    fvos_pkg::t_opcode                   r_op;
    logic signed [fvos_pkg::COORD_W-1:0] r_x;
    logic signed [fvos_pkg::COORD_W-1:0] r_y;
    logic signed [fvos_pkg::COORD_W-1:0] r_z;
    logic                                r_wval;
    logic [fvos_pkg::DIR_W-1:0]          r_dir;
    logic [fvos_pkg::DIR_W-1:0]          r_step;
    logic [fvos_pkg::CNT_W-1:0]          r_cnt;
    logic                                r_pin;
    logic [CW-1:0]                       r_px;
    logic [AW-1:0]                       r_paddr;
    logic                                r_wok;
    logic                                r_done;
    logic                                r_o_wacc;
    logic                                r_o_solid;
    logic [fvos_pkg::CNT_W-1:0]          r_o_cnt;

    fvos_pkg::t_hop  w_hop;
    logic            w_dir_ok;
    logic [PW-1:0]   w_px;
    logic [PW-1:0]   w_py;
    logic [PW-1:0]   w_pz;
    logic            w_pin;
    logic            w_parity_even;
    logic            w_last;
    logic [AW-1:0]   w_probe_addr;
    logic [AW-1:0]   w_mem_addr;
    logic            w_mem_we;
    logic [RW-1:0]   w_mem_wdata;
    logic [RW-1:0]   w_rd_row;
    logic [RW-1:0]   n_row;
    logic            w_hit;

    always_comb begin
        w_hop = '0;
        if (r_op == fvos_pkg::OP_COUNT) begin
            w_hop = fvos_pkg::hop_of(r_step);
        end else if (r_op == fvos_pkg::OP_HOP) begin
            w_hop = fvos_pkg::hop_of(r_dir);
        end
        w_dir_ok = !((r_op == fvos_pkg::OP_HOP) &&
                     (r_dir >= fvos_pkg::DIR_W'(fvos_pkg::DIR_COUNT)));
        w_px = {r_x[fvos_pkg::COORD_W-1], r_x} + {{(PW-2){w_hop.dx[1]}}, w_hop.dx};
        w_py = {r_y[fvos_pkg::COORD_W-1], r_y} + {{(PW-2){w_hop.dy[1]}}, w_hop.dy};
        w_pz = {r_z[fvos_pkg::COORD_W-1], r_z} + {{(PW-2){w_hop.dz[1]}}, w_hop.dz};
        w_pin = w_dir_ok &&
                !w_px[PW-1] && (w_px < GRID_LIM) &&
                !w_py[PW-1] && (w_py < GRID_LIM) &&
                !w_pz[PW-1] && (w_pz < GRID_LIM);
        w_parity_even = !(r_x[0] ^ r_y[0] ^ r_z[0]);
        w_last = (r_op != fvos_pkg::OP_COUNT) ||
                 (r_step == fvos_pkg::DIR_W'(fvos_pkg::DIR_COUNT - 1));
        w_probe_addr = {w_pz[CW-1:0], w_py[CW-1:0]};
    end

    always_comb begin
        n_row = w_rd_row;
        n_row[r_px] = r_wval;
    end

    always_comb begin
        unique case (r_state)
            S_CLEAR: begin
                w_mem_addr  = r_clr;
                w_mem_we    = 1'b1;
                w_mem_wdata = '0;
            end
            S_DONE: begin
                w_mem_addr  = r_paddr;
                w_mem_we    = (r_op == fvos_pkg::OP_WRITE) && r_wok;
                w_mem_wdata = n_row;
            end
            default: begin
                w_mem_addr  = w_probe_addr;
                w_mem_we    = 1'b0;
                w_mem_wdata = n_row;
            end
        endcase
    end

    assign w_hit = r_pin & w_rd_row[r_px];

    fvos_row_mem #(
        .AW (AW),
        .DW (RW)
    ) u_row_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_addr  (w_mem_addr),
        .i_wdata (w_mem_wdata),
        .o_rdata (w_rd_row)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == '1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_op    <= fvos_pkg::t_opcode'(i_opcode);
                        r_x     <= i_coord_x;
                        r_y     <= i_coord_y;
                        r_z     <= i_coord_z;
                        r_wval  <= i_write_value;
                        r_dir   <= i_direction;
                        r_step  <= '0;
                        r_cnt   <= '0;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    r_pin   <= w_pin;
                    r_px    <= w_px[CW-1:0];
                    r_paddr <= w_probe_addr;
                    r_wok   <= w_pin && w_parity_even;
                    r_step  <= r_step + 1'b1;
                    if (r_step != '0) begin
                        r_cnt <= r_cnt + {{(fvos_pkg::CNT_W-1){1'b0}}, w_hit};
                    end
                    if (w_last) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_done    <= 1'b1;
                    r_o_wacc  <= (r_op == fvos_pkg::OP_WRITE) && r_wok;
                    r_o_solid <= ((r_op == fvos_pkg::OP_READ) ||
                                  (r_op == fvos_pkg::OP_HOP)) && w_hit;
                    r_o_cnt   <= (r_op == fvos_pkg::OP_COUNT) ?
                                 r_cnt + {{(fvos_pkg::CNT_W-1){1'b0}}, w_hit} : '0;
                    r_state   <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy             = (r_state != S_IDLE);
    assign o_done           = r_done;
    assign o_write_accepted = r_o_wacc;
    assign o_solid          = r_o_solid;
    assign o_neighbor_count = r_o_cnt;

    a_done_after_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == S_DONE))
        else $error("result beat without a finishing cycle");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_neighbor_count <= fvos_pkg::CNT_W'(fvos_pkg::DIR_COUNT)))
        else $error("neighbor count above twelve");

    a_write_result_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_write_accepted) |-> (!o_solid && (o_neighbor_count == '0)))
        else $error("write result carries read fields");

    a_mem_write_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_we |-> ((r_state == S_CLEAR) || (r_state == S_DONE)))
        else $error("memory written outside clear or write-back");

endmodule

// File: tb/sv/fcc_voxel_occupancy_store_top_tb.sv
// Self-checking testbench for the FCC voxel occupancy store: directed and random beats
// are checked against an in-bench bitmap predictor. Depends on fvos_pkg and the top level.
module fcc_voxel_occupancy_store_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID        = fvos_pkg::GRID_SIZE_DEF;
    localparam int CELLS       = GRID * GRID * GRID;
    localparam int STALL_LIMIT = 5000;
    localparam int HOPS        = 12;

    typedef struct {
        fvos_pkg::t_opcode                   op;
        logic signed [fvos_pkg::COORD_W-1:0] x;
        logic signed [fvos_pkg::COORD_W-1:0] y;
        logic signed [fvos_pkg::COORD_W-1:0] z;
        logic                                wval;
        logic [fvos_pkg::DIR_W-1:0]          dir;
    } t_request;

    typedef struct {
        logic                       write_accepted;
        logic                       solid;
        logic [fvos_pkg::CNT_W-1:0] neighbor_count;
    } t_outcome;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                start = 1'b0;
    logic                                busy;
    logic [1:0]                          i_opcode = fvos_pkg::OP_READ;
    logic signed [fvos_pkg::COORD_W-1:0] i_coord_x = '0;
    logic signed [fvos_pkg::COORD_W-1:0] i_coord_y = '0;
    logic signed [fvos_pkg::COORD_W-1:0] i_coord_z = '0;
    logic                                i_write_value = 1'b0;
    logic [fvos_pkg::DIR_W-1:0]          i_direction = '0;
    logic                                o_done;
    logic                                o_write_accepted;
    logic                                o_solid;
    logic [fvos_pkg::CNT_W-1:0]          o_neighbor_count;

    bit       occupancy [CELLS];
    t_outcome pending_outcomes[$];
    int       n_errors = 0;
    int       stall_cycles = 0;
    bit       gaps_on = 1'b1;

    const int hop_dx[HOPS] = '{ 1,  1, -1, -1,  1,  1, -1, -1,  0,  0,  0,  0};
    const int hop_dy[HOPS] = '{ 1, -1,  1, -1,  0,  0,  0,  0,  1,  1, -1, -1};
    const int hop_dz[HOPS] = '{ 0,  0,  0,  0,  1, -1,  1, -1,  1, -1,  1, -1};

    fcc_voxel_occupancy_store_top #(.GRID_SIZE(GRID)) DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_opcode         (i_opcode),
        .i_coord_x        (i_coord_x),
        .i_coord_y        (i_coord_y),
        .i_coord_z        (i_coord_z),
        .i_write_value    (i_write_value),
        .i_direction      (i_direction),
        .o_done           (o_done),
        .o_write_accepted (o_write_accepted),
        .o_solid          (o_solid),
        .o_neighbor_count (o_neighbor_count)
    );

    always #5 i_clk = ~i_clk;

    function automatic bit in_grid(input int x, input int y, input int z);
        return x >= 0 && x < GRID && y >= 0 && y < GRID && z >= 0 && z < GRID;
    endfunction

    function automatic bit cell_bit(input int x, input int y, input int z);
        if (!in_grid(x, y, z)) begin
            return 1'b0;
        end
        return occupancy[x + y * GRID + z * GRID * GRID];
    endfunction

    function automatic bit neighbor_bit(input int x, input int y, input int z, input int d);
        if (d >= HOPS) begin
            return 1'b0;
        end
        return cell_bit(x + hop_dx[d], y + hop_dy[d], z + hop_dz[d]);
    endfunction

    function automatic t_outcome occupancy_outcome(input t_request req);
        t_outcome res;
        int x;
        int y;
        int z;
        int total;
        x = req.x;
        y = req.y;
        z = req.z;
        res = '{write_accepted: 1'b0, solid: 1'b0, neighbor_count: '0};
        case (req.op)
            fvos_pkg::OP_WRITE: begin
                if (in_grid(x, y, z) && ((x + y + z) & 1) == 0) begin
                    occupancy[x + y * GRID + z * GRID * GRID] = req.wval;
                    res.write_accepted = 1'b1;
                end
            end
            fvos_pkg::OP_READ: res.solid = cell_bit(x, y, z);
            fvos_pkg::OP_HOP: res.solid = neighbor_bit(x, y, z, int'(req.dir));
            default: begin
                total = 0;
                for (int d = 0; d < HOPS; d++) begin
                    total += neighbor_bit(x, y, z, d);
                end
                res.neighbor_count = fvos_pkg::CNT_W'(total);
            end
        endcase
        return res;
    endfunction

    task automatic send_beat(input t_request req);
        i_opcode      <= req.op;
        i_coord_x     <= req.x;
        i_coord_y     <= req.y;
        i_coord_z     <= req.z;
        i_write_value <= req.wval;
        i_direction   <= req.dir;
        do begin
            start <= !(gaps_on && ($urandom_range(99) < 17));
            @(posedge i_clk);
        end while (!(start && !busy));
        pending_outcomes.push_back(occupancy_outcome(req));
    endtask

    task automatic send_op(input fvos_pkg::t_opcode op, input int x, input int y,
                           input int z, input bit wval, input int dir);
        t_request req;
        req = '{op: op, x: fvos_pkg::COORD_W'(x), y: fvos_pkg::COORD_W'(y),
                z: fvos_pkg::COORD_W'(z), wval: wval, dir: fvos_pkg::DIR_W'(dir)};
        send_beat(req);
    endtask

    task automatic wait_for_results();
        start <= 1'b0;
        while (pending_outcomes.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    function automatic logic [fvos_pkg::COORD_W-1:0] pick_coord();
        int m;
        m = $urandom_range(99);
        if (m < 55) begin
            return fvos_pkg::COORD_W'($urandom_range(5));
        end else if (m < 85) begin
            return fvos_pkg::COORD_W'(int'($urandom_range(GRID + 1)) - 1);
        end
        return fvos_pkg::COORD_W'($urandom());
    endfunction

    function automatic t_request random_request();
        t_request req;
        int m;
        m = $urandom_range(99);
        if (m < 40) begin
            req.op = fvos_pkg::OP_WRITE;
        end else if (m < 60) begin
            req.op = fvos_pkg::OP_READ;
        end else if (m < 80) begin
            req.op = fvos_pkg::OP_HOP;
        end else begin
            req.op = fvos_pkg::OP_COUNT;
        end
        req.x    = pick_coord();
        req.y    = pick_coord();
        req.z    = pick_coord();
        req.wval = ($urandom_range(99) < 65);
        if (req.op == fvos_pkg::OP_HOP && $urandom_range(99) < 85) begin
            req.dir = fvos_pkg::DIR_W'($urandom_range(HOPS - 1));
        end else begin
            req.dir = fvos_pkg::DIR_W'($urandom());
        end
        return req;
    endfunction

    task automatic test_directed();
        send_op(fvos_pkg::OP_WRITE, 0, 0, 0, 1'b1, 0);
        send_op(fvos_pkg::OP_WRITE, 1, 1, 0, 1'b1, 15);
        send_op(fvos_pkg::OP_WRITE, 1, 0, 1, 1'b1, 0);
        send_op(fvos_pkg::OP_WRITE, 0, 1, 1, 1'b1, 0);
        send_op(fvos_pkg::OP_WRITE, 1, 0, 0, 1'b1, 0);
        send_op(fvos_pkg::OP_WRITE, 31, 31, 30, 1'b1, 0);
        send_op(fvos_pkg::OP_WRITE, 31, 31, 31, 1'b1, 0);
        send_op(fvos_pkg::OP_WRITE, -1, 0, 1, 1'b1, 0);
        send_op(fvos_pkg::OP_WRITE, 32, 0, 0, 1'b1, 0);
        send_op(fvos_pkg::OP_WRITE, -64, -64, -64, 1'b1, 0);
        send_op(fvos_pkg::OP_WRITE, 63, 63, 63, 1'b1, 0);
        send_op(fvos_pkg::OP_READ, 0, 0, 0, 1'b0, 0);
        send_op(fvos_pkg::OP_READ, 31, 31, 30, 1'b0, 0);
        send_op(fvos_pkg::OP_READ, -64, 63, -1, 1'b0, 0);
        send_op(fvos_pkg::OP_HOP, 0, 0, 0, 1'b0, 0);
        send_op(fvos_pkg::OP_HOP, 0, 0, 0, 1'b0, 8);
        send_op(fvos_pkg::OP_HOP, 0, 0, 0, 1'b0, 3);
        send_op(fvos_pkg::OP_HOP, 0, 0, 0, 1'b0, 12);
        send_op(fvos_pkg::OP_HOP, 0, 0, 0, 1'b0, 15);
        send_op(fvos_pkg::OP_COUNT, 0, 0, 0, 1'b0, 0);
        send_op(fvos_pkg::OP_COUNT, 31, 31, 31, 1'b0, 0);
        send_op(fvos_pkg::OP_COUNT, 63, -64, 0, 1'b0, 0);
        send_op(fvos_pkg::OP_WRITE, 1, 1, 0, 1'b0, 0);
        send_op(fvos_pkg::OP_COUNT, 0, 0, 0, 1'b0, 0);
    endtask

    task automatic test_random(input int beats);
        for (int i = 0; i < beats; i++) begin
            send_beat(random_request());
        end
    endtask

    task automatic test_dense_full_cluster();
        for (int z = 0; z < 4; z++) begin
            for (int y = 0; y < 4; y++) begin
                for (int x = 0; x < 4; x++) begin
                    send_op(fvos_pkg::OP_WRITE, x, y, z, 1'b1, 0);
                end
            end
        end
        send_op(fvos_pkg::OP_COUNT, 1, 1, 2, 1'b0, 0);
        send_op(fvos_pkg::OP_COUNT, 2, 2, 2, 1'b0, 0);
    endtask

    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && ((start && !busy) || o_done)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
        if (i_rst_n && o_done) begin
            if (pending_outcomes.size() == 0) begin
                $error("result beat with no expectation pending");
                n_errors++;
            end else begin
                want = pending_outcomes.pop_front();
                if (o_write_accepted !== want.write_accepted) begin
                    $error("write_accepted: expected %0d, got %0d",
                           want.write_accepted, o_write_accepted);
                    n_errors++;
                end
                if (o_solid !== want.solid) begin
                    $error("solid: expected %0d, got %0d", want.solid, o_solid);
                    n_errors++;
                end
                if (o_neighbor_count !== want.neighbor_count) begin
                    $error("neighbor_count: expected %0d, got %0d",
                           want.neighbor_count, o_neighbor_count);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        wait_for_results();
        test_dense_full_cluster();
        test_random(650);
        wait_for_results();
        gaps_on = 1'b0;
        test_random(350);
        gaps_on = 1'b1;
        test_random(620);
        wait_for_results();
        repeat (20) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
